FILE: src/crl_pkg.sv
// ----------------------------------------------------------------------------
// crl_pkg
// Shared types, constants and arithmetic helpers of the closed-loop
// Catmull-Rom evaluator.
// ----------------------------------------------------------------------------
package crl_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned NUM_W      = 7;
  localparam int unsigned MOD_STEPS  = 32;
  localparam int unsigned SEG_W      = 6;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SEG_STEPS  = SEG_W + FRAC_W;
  localparam int unsigned POLY_DEPTH = 8;
  localparam int unsigned H_W        = 48;
  localparam int unsigned P_W        = 64;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic CFG_NUM_POINTS  = 1'b0;
  localparam logic CFG_LOOP_PERIOD = 1'b1;

  typedef logic signed [H_W-1:0] hval_t;
  typedef logic signed [P_W-1:0] prod_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic       cmd;
    logic [5:0] slot;
    point_t     pt;
  } tag_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic b,
                                           input logic [31:0] per);
    logic [32:0] t;
    logic [32:0] d;
    t = {rem, b};
    d = t - {1'b0, per};
    if (t >= {1'b0, per}) begin
      return {1'b1, d[31:0]};
    end else begin
      return {1'b0, t[31:0]};
    end
  endfunction

  function automatic prod_t mul_f(input hval_t h, input logic [FRAC_W-1:0] f);
    return prod_t'(h) * prod_t'({1'b0, f});
  endfunction

  // Floor division by 2^16.
  function automatic hval_t fshr16(input prod_t m);
    prod_t t;
    t = m >>> 16;
    return hval_t'(t);
  endfunction

  // Divide by 512 rounding half up, then saturate to 32 bits.
  function automatic logic signed [31:0] rnd_sat(input hval_t h);
    hval_t t;
    t = (h + hval_t'(256)) >>> 9;
    if (t[H_W-1:31] == '0 || t[H_W-1:31] == '1) begin
      return t[31:0];
    end else if (t[H_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

FILE: src/crl_if.sv
// ----------------------------------------------------------------------------
// crl_in_if / crl_out_if
// Valid/ready channels carrying the command items and the curve results.
// ----------------------------------------------------------------------------
interface crl_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [5:0]         point_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [31:0]        eval_time;

  modport source (output valid, cmd, point_index, coord_x, coord_y, coord_z, eval_time,
                  input ready);
  modport sink (input valid, cmd, point_index, coord_x, coord_y, coord_z, eval_time,
                output ready);
endinterface

interface crl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

FILE: src/crl_mod_pipe.sv
// ----------------------------------------------------------------------------
// crl_mod_pipe
// Pipelined restoring divider giving the time modulo the loop period,
// one dividend bit per stage.
// ----------------------------------------------------------------------------
module crl_mod_pipe (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  crl_pkg::tag_t tag_i,
  input  logic [31:0]   time_i,
  input  logic [31:0]   per_i,
  output logic          valid_o,
  output crl_pkg::tag_t tag_o,
  output logic [31:0]   rem_o
);
  import crl_pkg::*;

  logic        vld_q [MOD_STEPS+1];
  tag_t        tag_q [MOD_STEPS+1];
  logic [31:0] rem_q [MOD_STEPS+1];
  logic [31:0] dvd_q [MOD_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      rem_q[0] <= '0;
      dvd_q[0] <= time_i;
    end
  end

  for (genvar i = 0; i < MOD_STEPS; i++) begin : g_step
    logic [32:0] st;
    assign st = div_step(rem_q[i], dvd_q[i][31], per_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i+1] <= tag_q[i];
        rem_q[i+1] <= st[31:0];
        dvd_q[i+1] <= {dvd_q[i][30:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[MOD_STEPS];
  assign tag_o   = tag_q[MOD_STEPS];
  assign rem_o   = rem_q[MOD_STEPS];

endmodule

FILE: src/crl_seg_pipe.sv
// ----------------------------------------------------------------------------
// crl_seg_pipe
// Scales the loop phase by the point count and divides by the period,
// giving the segment index and a 16-bit fraction, one bit per stage.
// ----------------------------------------------------------------------------
module crl_seg_pipe (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  crl_pkg::tag_t              tag_i,
  input  logic [31:0]                phase_i,
  input  logic [crl_pkg::NUM_W-1:0]  num_i,
  input  logic [31:0]                per_i,
  output logic                       valid_o,
  output crl_pkg::tag_t              tag_o,
  output logic [crl_pkg::SEG_W-1:0]  seg_o,
  output logic [crl_pkg::FRAC_W-1:0] frac_o
);
  import crl_pkg::*;

  logic                 vld_q [SEG_STEPS+1];
  tag_t                 tag_q [SEG_STEPS+1];
  logic [31:0]          rem_q [SEG_STEPS+1];
  logic [SEG_STEPS-1:0] dvd_q [SEG_STEPS+1];
  logic [SEG_STEPS-1:0] quo_q [SEG_STEPS+1];
  logic [38:0]          prod;

  assign prod = {7'b0, phase_i} * {32'b0, num_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // The product is below period * 64, so its upper part already lies below
  // the period and only the low six bits remain as quotient bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      rem_q[0] <= prod[37:6];
      dvd_q[0] <= {prod[5:0], {FRAC_W{1'b0}}};
      quo_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < SEG_STEPS; i++) begin : g_step
    logic [32:0] st;
    assign st = div_step(rem_q[i], dvd_q[i][SEG_STEPS-1], per_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i+1] <= tag_q[i];
        rem_q[i+1] <= st[31:0];
        dvd_q[i+1] <= {dvd_q[i][SEG_STEPS-2:0], 1'b0};
        quo_q[i+1] <= {quo_q[i][SEG_STEPS-2:0], st[32]};
      end
    end
  end

  assign valid_o = vld_q[SEG_STEPS];
  assign tag_o   = tag_q[SEG_STEPS];
  assign seg_o   = quo_q[SEG_STEPS][SEG_STEPS-1:FRAC_W];
  assign frac_o  = quo_q[SEG_STEPS][FRAC_W-1:0];

endmodule

FILE: src/crl_fetch.sv
// ----------------------------------------------------------------------------
// crl_fetch
// Control point store: performs point writes in order with evaluations and
// reads the four wrapped neighbours of a segment from four bank copies.
// ----------------------------------------------------------------------------
module crl_fetch (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  crl_pkg::tag_t              tag_i,
  input  logic [crl_pkg::SEG_W-1:0]  seg_i,
  input  logic [crl_pkg::FRAC_W-1:0] frac_i,
  input  logic [crl_pkg::NUM_W-1:0]  num_i,
  output logic                       valid_o,
  output logic [crl_pkg::FRAC_W-1:0] frac_o,
  output crl_pkg::point_t            pts_o [4]
);
  import crl_pkg::*;

  logic              vld_q;
  tag_t              tag_q;
  logic [FRAC_W-1:0] frac_q;
  logic [IDX_W-1:0]  idx_q [4];
  logic [IDX_W-1:0]  idx_d [4];
  logic [NUM_W-1:0]  nxt2;
  logic [NUM_W-1:0]  nxt3;
  logic              wr_en;
  logic              vld1_q;
  logic [FRAC_W-1:0] frac1_q;

  always_comb begin
    idx_d[1] = IDX_W'(seg_i);
    idx_d[0] = (seg_i == '0) ? IDX_W'(num_i - NUM_W'(1)) : IDX_W'(seg_i - SEG_W'(1));
    nxt2     = NUM_W'(seg_i) + NUM_W'(1);
    idx_d[2] = (nxt2 == num_i) ? '0 : IDX_W'(nxt2);
    nxt3     = NUM_W'(idx_d[2]) + NUM_W'(1);
    idx_d[3] = (nxt3 == num_i) ? '0 : IDX_W'(nxt3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld_q  <= valid_i;
      vld1_q <= vld_q && (tag_q.cmd == CMD_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q   <= tag_i;
      frac_q  <= frac_i;
      idx_q   <= idx_d;
      frac1_q <= frac_q;
    end
  end

  assign wr_en = en_i && vld_q && (tag_q.cmd == CMD_WRITE);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    point_t mem [MAX_POINTS];
    point_t rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[IDX_W'(tag_q.slot)] <= tag_q.pt;
      end
      if (en_i) begin
        rd_q <= mem[idx_q[b]];
      end
    end

    assign pts_o[b] = rd_q;
  end

  assign valid_o = vld1_q;
  assign frac_o  = frac1_q;

endmodule

FILE: src/crl_horner.sv
// ----------------------------------------------------------------------------
// crl_horner
// One coordinate axis: Catmull-Rom coefficients and Horner evaluation of
// position and derivative, with Horner multiplication and addition stages in turn.
// ----------------------------------------------------------------------------
module crl_horner (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [crl_pkg::FRAC_W-1:0] f_i,
  input  logic signed [31:0]         p_i [4],
  output logic signed [31:0]         pos_o,
  output logic signed [31:0]         vel_o
);
  import crl_pkg::*;

  hval_t e0, e1, e2, e3;
  hval_t c3_q, c2_q, c1_q, p1_q;
  hval_t c2_1_q, c1_1_q, p1_1_q;
  hval_t c1_2_q, p1_2_q;
  hval_t c1_3_q, p1_3_q;
  hval_t p1_4_q, p1_5_q;
  prod_t mp1_q, mv1_q, mp3_q, mv3_q, mp5_q;
  hval_t hp2_q, hv2_q, hp4_q, hv4_q, hv5_q, hp6_q, hv6_q;
  logic [FRAC_W-1:0] f_q [5];
  logic signed [31:0] pos_q, vel_q;

  assign e0 = hval_t'(p_i[0]);
  assign e1 = hval_t'(p_i[1]);
  assign e2 = hval_t'(p_i[2]);
  assign e3 = hval_t'(p_i[3]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3_q   <= e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
      c2_q   <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c1_q   <= e2 - e0;
      p1_q   <= e1;
      f_q[0] <= f_i;

      mp1_q  <= mul_f(c3_q <<< 8, f_q[0]);
      mv1_q  <= mul_f((c3_q <<< 9) + (c3_q <<< 8), f_q[0]);
      c2_1_q <= c2_q;
      c1_1_q <= c1_q;
      p1_1_q <= p1_q;
      f_q[1] <= f_q[0];

      hp2_q  <= fshr16(mp1_q) + (c2_1_q <<< 8);
      hv2_q  <= fshr16(mv1_q) + (c2_1_q <<< 9);
      c1_2_q <= c1_1_q;
      p1_2_q <= p1_1_q;
      f_q[2] <= f_q[1];

      mp3_q  <= mul_f(hp2_q, f_q[2]);
      mv3_q  <= mul_f(hv2_q, f_q[2]);
      c1_3_q <= c1_2_q;
      p1_3_q <= p1_2_q;
      f_q[3] <= f_q[2];

      hp4_q  <= fshr16(mp3_q) + (c1_3_q <<< 8);
      hv4_q  <= fshr16(mv3_q) + (c1_3_q <<< 8);
      p1_4_q <= p1_3_q;
      f_q[4] <= f_q[3];

      mp5_q  <= mul_f(hp4_q, f_q[4]);
      hv5_q  <= hv4_q;
      p1_5_q <= p1_4_q;

      hp6_q  <= fshr16(mp5_q) + (p1_5_q <<< 9);
      hv6_q  <= hv5_q;

      pos_q  <= rnd_sat(hp6_q);
      vel_q  <= rnd_sat(hv6_q);
    end
  end

  assign pos_o = pos_q;
  assign vel_o = vel_q;

endmodule

FILE: src/catmull_rom_loop_evaluator.sv
// ----------------------------------------------------------------------------
// catmull_rom_loop_evaluator
// Closed-loop Catmull-Rom spline evaluator over signed Q16.16 3D points.
//
//   Channel   Dir  Carries
//   in_ch     in   point write (cmd 0) or evaluation request (cmd 1)
//   out_ch    out  position and derivative for each evaluation
//   cfg_*     in   point count and loop period registers
//
// One transaction enters per cycle while the output is not held. A request
// passes 66 register stages: 33 in the modulo divider, 23 in the segment
// divider, two store stages and eight Horner stages before its result is
// offered. Point writes travel the same pipeline, so they stay in order with
// evaluations. When the output stage is held, the whole pipeline stalls.
// Reset clears the valid bits and sets the registers to four points and a
// period of 65536; the point store holds nothing until written.
// ----------------------------------------------------------------------------
module catmull_rom_loop_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  crl_in_if.sink      in_ch,
  crl_out_if.source   out_ch
);
  import crl_pkg::*;

  logic [NUM_W-1:0]  num_points_q;
  logic [31:0]       loop_period_q;
  logic [NUM_W-1:0]  num_eff;
  logic [31:0]       per_eff;
  logic              en;
  tag_t              in_tag;
  logic              mod_vld, seg_vld, ftc_vld;
  tag_t              mod_tag, seg_tag;
  logic [31:0]       phase;
  logic [SEG_W-1:0]  seg;
  logic [FRAC_W-1:0] frac, ftc_frac;
  point_t            pts [4];
  logic              vld_q [POLY_DEPTH];
  logic signed [31:0] px [4];
  logic signed [31:0] py [4];
  logic signed [31:0] pz [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q  <= NUM_W'(4);
      loop_period_q <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_POINTS:  num_points_q  <= cfg_wdata_i[NUM_W-1:0];
        CFG_LOOP_PERIOD: loop_period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_points_q == '0) begin
      num_eff = NUM_W'(1);
    end else if (num_points_q > NUM_W'(MAX_POINTS)) begin
      num_eff = NUM_W'(MAX_POINTS);
    end else begin
      num_eff = num_points_q;
    end
    per_eff = (loop_period_q == '0) ? 32'd1 : loop_period_q;
  end

  assign en          = !vld_q[POLY_DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign in_tag.cmd  = in_ch.cmd;
  assign in_tag.slot = in_ch.point_index;
  assign in_tag.pt.x = in_ch.coord_x;
  assign in_tag.pt.y = in_ch.coord_y;
  assign in_tag.pt.z = in_ch.coord_z;

  crl_mod_pipe u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_ch.valid),
    .tag_i   (in_tag),
    .time_i  (in_ch.eval_time),
    .per_i   (per_eff),
    .valid_o (mod_vld),
    .tag_o   (mod_tag),
    .rem_o   (phase)
  );

  crl_seg_pipe u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mod_vld),
    .tag_i   (mod_tag),
    .phase_i (phase),
    .num_i   (num_eff),
    .per_i   (per_eff),
    .valid_o (seg_vld),
    .tag_o   (seg_tag),
    .seg_o   (seg),
    .frac_o  (frac)
  );

  crl_fetch u_fetch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (seg_vld),
    .tag_i   (seg_tag),
    .seg_i   (seg),
    .frac_i  (frac),
    .num_i   (num_eff),
    .valid_o (ftc_vld),
    .frac_o  (ftc_frac),
    .pts_o   (pts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POLY_DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= ftc_vld;
      for (int i = 1; i < POLY_DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i] = pts[i].x;
      py[i] = pts[i].y;
      pz[i] = pts[i].z;
    end
  end

  crl_horner u_hx (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   (ftc_frac),
    .p_i   (px),
    .pos_o (out_ch.pos_x),
    .vel_o (out_ch.vel_x)
  );

  crl_horner u_hy (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   (ftc_frac),
    .p_i   (py),
    .pos_o (out_ch.pos_y),
    .vel_o (out_ch.vel_y)
  );

  crl_horner u_hz (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   (ftc_frac),
    .p_i   (pz),
    .pos_o (out_ch.pos_z),
    .vel_o (out_ch.vel_z)
  );

  assign out_ch.valid = vld_q[POLY_DEPTH-1];

endmodule
